// File: rtl/core/msp_pkg.sv
// Package for the multi-stack shared pool: payload types, codes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package msp_pkg;

    localparam int POOL_SIZE_DEF   = 16;
    localparam int NUM_STACKS_DEF  = 4;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_TOP  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_ID = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         stack_id;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [1:0]         status;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic clr;
        logic take;
        logic eval;
        logic commit;
        logic load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic needs_mem;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/multi_stack_shared_pool.sv
// Top level of the multi-stack shared pool: controller plus datapath.
// Depends on msp_pkg, msp_ctrl, msp_dp (and msp_ram through msp_dp).
//
//   channel | signals                      | direction | carries
//   req     | req_valid, req_ready, req    | in        | kind, stack_id, value
//   rsp     | rsp_valid, rsp_ready, rsp    | out       | top_value, status
//
// A request that touches the pool steps through accept, evaluate, RAM read and
// relink, and result; one that fails or is kind 3 skips the RAM read and relink
// step. A new request is taken only after the result step.
// After reset a clearing pass builds the free list in the link RAM; req_ready
// stays low during it.
// A stalled result sits in the output register while the next request is taken
// and evaluated; the block holds before loading a new result until it drains.
`default_nettype none

module multi_stack_shared_pool #(
    parameter int POOL_SIZE   = msp_pkg::POOL_SIZE_DEF,
    parameter int NUM_STACKS  = msp_pkg::NUM_STACKS_DEF,
    parameter int VALUE_WIDTH = msp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire msp_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output msp_pkg::rsp_t      rsp
);

    import msp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    msp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    msp_dp #(
        .POOL_SIZE   (POOL_SIZE),
        .NUM_STACKS  (NUM_STACKS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// File: rtl/core/msp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/msp_ctrl.sv
// Controller for the multi-stack shared pool: sequences clear, evaluate,
// commit and result steps. Depends on msp_pkg.
`default_nettype none

module msp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    input  wire msp_pkg::sts_t sts,
    output msp_pkg::cmd_t      cmd
);

    import msp_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_COMMIT,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;
    logic   slot_free;

    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;

    assign cmd.clr    = (state_reg == S_CLEAR);
    assign cmd.take   = (state_reg == S_IDLE) && req_valid;
    assign cmd.eval   = (state_reg == S_EVAL);
    assign cmd.commit = (state_reg == S_COMMIT);
    assign cmd.load   = (state_reg == S_DONE) && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result loads in the same cycle the old one drains
            if ((state_reg == S_DONE) && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (sts.clr_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= sts.needs_mem ? S_COMMIT : S_DONE;
                end
                S_COMMIT:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold the result until the output register frees up
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/msp_dp.sv
// Datapath for the multi-stack shared pool: head registers, free head,
// value and link RAMs, result registers. Depends on msp_pkg and msp_ram.
`default_nettype none

module msp_dp #(
    parameter int POOL_SIZE   = msp_pkg::POOL_SIZE_DEF,
    parameter int NUM_STACKS  = msp_pkg::NUM_STACKS_DEF,
    parameter int VALUE_WIDTH = msp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire msp_pkg::req_t req,
    input  wire msp_pkg::cmd_t cmd,
    output msp_pkg::sts_t      sts,
    output msp_pkg::rsp_t      rsp
);

    import msp_pkg::*;

    localparam int AW = $clog2(POOL_SIZE);
    localparam int IW = $clog2(POOL_SIZE + 1);
    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [IW-1:0] END_MARK = IW'(POOL_SIZE);

    req_t          req_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [IW-1:0] free_head_reg;
    logic [IW-1:0] head_reg [NUM_STACKS];
    logic [AW-1:0] tgt_reg;
    rsp_t          res_reg;
    rsp_t          rsp_reg;

    logic [SW-1:0] sid_idx;
    logic          sid_ok;
    logic          is_push;
    logic          is_pop_top;
    logic [IW-1:0] cur_head;
    logic          head_end;
    logic          free_end;
    logic [1:0]    ev_status;
    logic [IW-1:0] tgt;

    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [IW-1:0] link_wdata;
    logic [IW-1:0] link_rd;
    logic [63:0]   val_sx;
    logic [VALUE_WIDTH-1:0] val_rd;
    logic [63:0]   val_rd64;

    assign sid_idx    = req_reg.stack_id[SW-1:0];
    assign sid_ok     = 4'(req_reg.stack_id) < 4'(NUM_STACKS);
    assign is_push    = (req_reg.kind == KIND_PUSH);
    assign is_pop_top = (req_reg.kind inside {KIND_POP, KIND_TOP});
    assign cur_head   = head_reg[sid_idx];
    assign head_end   = (cur_head >= END_MARK);
    assign free_end   = (free_head_reg >= END_MARK);
    assign tgt        = is_push ? free_head_reg : cur_head;

    always_comb
    begin
        if (req_reg.kind == KIND_NONE)
            ev_status = ST_OK;
        else if (!sid_ok)
            ev_status = ST_BAD_ID;
        else if (is_push)
            ev_status = free_end ? ST_FULL : ST_OK;
        else if (is_pop_top)
            ev_status = head_end ? ST_EMPTY : ST_OK;
        else
            ev_status = ST_OK;
    end

    assign sts.needs_mem = sid_ok && (req_reg.kind != KIND_NONE) && (ev_status == ST_OK);
    assign sts.clr_last  = cmd.clr && (clr_cnt_reg == AW'(POOL_SIZE - 1));

    // link RAM: clearing pass writes entry i -> i+1; a push or pop commit relinks the target
    assign link_we    = cmd.clr || (cmd.commit && (is_push || req_reg.kind == KIND_POP));
    assign link_waddr = cmd.clr ? clr_cnt_reg : tgt_reg;
    assign link_wdata = cmd.clr ? (IW'(clr_cnt_reg) + IW'(1))
                                : (is_push ? cur_head : free_head_reg);

    msp_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_SIZE)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (tgt[AW-1:0]),
        .rdata (link_rd)
    );

    assign val_sx = {{32{req_reg.value[31]}}, req_reg.value};

    msp_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (POOL_SIZE)
    ) u_value_ram (
        .clk   (clk),
        .we    (cmd.eval && sts.needs_mem && is_push),
        .waddr (free_head_reg[AW-1:0]),
        .wdata (val_sx[VALUE_WIDTH-1:0]),
        .raddr (tgt[AW-1:0]),
        .rdata (val_rd)
    );

    assign val_rd64 = 64'(val_rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            free_head_reg <= '0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                head_reg[i] <= END_MARK;
            end
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.commit)
            begin
                if (is_push)
                begin
                    free_head_reg     <= link_rd;
                    head_reg[sid_idx] <= IW'(tgt_reg);
                end
                else if (req_reg.kind == KIND_POP)
                begin
                    head_reg[sid_idx] <= link_rd;
                    free_head_reg     <= IW'(tgt_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg <= req;
        end
        if (cmd.eval)
        begin
            tgt_reg           <= tgt[AW-1:0];
            res_reg.status    <= ev_status;
            res_reg.top_value <= '0;
        end
        if (cmd.commit && req_reg.kind == KIND_TOP)
        begin
            res_reg.top_value <= val_rd64[31:0];
        end
        if (cmd.load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp = rsp_reg;

    // a push links the former free head in front of the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && is_push |=> head_reg[$past(sid_idx)] == IW'($past(tgt_reg)))
        else $error("push did not link the taken entry as stack head");

    // a request that fails or needs no memory step leaves the free list alone
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && !sts.needs_mem |=> $stable(free_head_reg))
        else $error("free head changed on a request without commit");

    // at evaluate, the free head is never also the head of the addressed stack
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && sid_ok && !free_end && !head_end |-> free_head_reg != cur_head)
        else $error("free head and stack head share an entry");

endmodule

`default_nettype wire

// File: dv/tb_multi_stack_shared_pool.sv
// Testbench for multi_stack_shared_pool: directed and random push/pop/top traffic
// checked against an in-bench model of the linked stacks and free list.
// Depends on msp_pkg and the multi_stack_shared_pool RTL.
`default_nettype none

module tb_multi_stack_shared_pool;
    import msp_pkg::*;

    localparam int POOL       = POOL_SIZE_DEF;
    localparam int NSTK       = NUM_STACKS_DEF;
    localparam int PTR_W      = $clog2(POOL + 1);
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SHOWN_ERRORS = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // model of the pool: values, links, free list head and stack heads
    logic [31:0]      slot_value [POOL];
    logic [PTR_W-1:0] slot_link  [POOL];
    logic [PTR_W-1:0] free_ptr;
    logic [PTR_W-1:0] head_ptr   [NSTK];

    rsp_t expected_rsp_q[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    int   ready_hold  = 0;
    bit   no_idle     = 1'b0;

    multi_stack_shared_pool u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void clear_pool_model();
        for (int i = 0; i < POOL; i++)
        begin
            slot_value[i] = '0;
            slot_link[i]  = PTR_W'(i + 1);
        end
        free_ptr = '0;
        for (int s = 0; s < NSTK; s++)
            head_ptr[s] = PTR_W'(POOL);
    endfunction

    // Update the model for one request and return the response it gives.
    function automatic rsp_t apply_stack_request(req_t item);
        rsp_t             o;
        logic [PTR_W-1:0] n;
        o = '0;
        o.status = ST_OK;
        if (item.kind != KIND_NONE)
        begin
            if (item.stack_id >= NSTK)
                o.status = ST_BAD_ID;
            else if (item.kind == KIND_PUSH)
            begin
                n = free_ptr;
                if (n >= POOL)
                    o.status = ST_FULL;
                else
                begin
                    free_ptr                = slot_link[n];
                    slot_value[n]           = item.value;
                    slot_link[n]            = head_ptr[item.stack_id];
                    head_ptr[item.stack_id] = n;
                end
            end
            else
            begin
                n = head_ptr[item.stack_id];
                if (n >= POOL)
                    o.status = ST_EMPTY;
                else if (item.kind == KIND_TOP)
                    o.top_value = slot_value[n];
                else
                begin
                    head_ptr[item.stack_id] = slot_link[n];
                    slot_link[n]            = free_ptr;
                    free_ptr                = n;
                end
            end
        end
        return o;
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
            $display("ERROR: %s", msg);
    endfunction

    // Hold valid and payload until the transfer, then record the expected response.
    task automatic send_request(input req_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(negedge clk);
        while (!req_ready)
            @(negedge clk);
        @(posedge clk);
        expected_rsp_q.push_back(apply_stack_request(item));
    endtask

    task automatic send_op(input logic [1:0] kind, input logic [2:0] sid,
                           input logic [31:0] value);
        req_t item;
        item.kind     = kind;
        item.stack_id = sid;
        item.value    = value;
        send_request(item);
    endtask

    // Response side: random stalls, short and long, with stretches of none.
    always @(posedge clk)
    begin
        int g;
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (rsp_ready || no_idle)
        begin
            g = pick_gap();
            if (g > 0)
            begin
                rsp_ready  <= 1'b0;
                ready_hold <= g - 1;
            end
            else
            begin
                rsp_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end
        end
        else
        begin
            rsp_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end
    end

    // Sample at the falling edge: a transfer seen here completes at the next rising edge.
    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
                note_error($sformatf("response with none expected: top_value=%0d status=%0d",
                                     rsp.top_value, rsp.status));
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.top_value !== want.top_value)
                    note_error($sformatf("top_value expected %0d got %0d",
                                         want.top_value, rsp.top_value));
                if (rsp.status !== want.status)
                    note_error($sformatf("status expected %0d got %0d",
                                         want.status, rsp.status));
            end
        end
    end

    always @(negedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_empty_stacks();
        send_op(KIND_POP, 3'd0, 32'h1234_5678);
        send_op(KIND_TOP, 3'(NSTK - 1), 32'hFFFF_FFFF);
    endtask

    // Bad id wins over the empty and full checks.
    task automatic test_bad_stack_id();
        send_op(KIND_PUSH, 3'(NSTK), 32'hA5A5_A5A5);
        send_op(KIND_POP, 3'd7, 32'h0);
        send_op(KIND_TOP, 3'd5, 32'h5A5A_5A5A);
        send_op(KIND_PUSH, 3'd6, 32'h8000_0000);
    endtask

    task automatic test_unused_kind();
        send_op(KIND_NONE, 3'd0, 32'hFFFF_FFFF);
        send_op(KIND_NONE, 3'd7, 32'h7FFF_FFFF);
    endtask

    task automatic test_value_extremes();
        send_op(KIND_PUSH, 3'd0, 32'h7FFF_FFFF);
        send_op(KIND_PUSH, 3'd3, 32'h8000_0000);
        send_op(KIND_PUSH, 3'd1, 32'h0000_0000);
        send_op(KIND_PUSH, 3'd2, 32'hFFFF_FFFF);
        for (int s = 0; s < NSTK; s++)
            send_op(KIND_TOP, 3'(s), 32'h0);
        for (int s = 0; s < NSTK; s++)
            send_op(KIND_POP, 3'(s), 32'hFFFF_FFFF);
        send_op(KIND_TOP, 3'd1, 32'h0);
    endtask

    // fill_bias 0 favors push (drives the pool to full), 1 favors pop, 2 is mixed.
    function automatic req_t random_request(int fill_bias);
        req_t item;
        int   sel;
        int   k;
        item.value    = $urandom;
        item.stack_id = 3'($urandom_range(0, NSTK - 1));
        sel = $urandom_range(0, 99);
        if (sel < 4)
        begin
            item.kind     = KIND_NONE;
            item.stack_id = 3'($urandom_range(0, 7));
        end
        else if (sel < 12)
        begin
            item.kind     = 2'($urandom_range(0, 2));
            item.stack_id = 3'($urandom_range(NSTK, 7));
        end
        else
        begin
            k = $urandom_range(0, 99);
            case (fill_bias)
                0: item.kind = (k < 70) ? KIND_PUSH : (k < 85) ? KIND_POP : KIND_TOP;
                1: item.kind = (k < 20) ? KIND_PUSH : (k < 80) ? KIND_POP : KIND_TOP;
                default: item.kind = (k < 40) ? KIND_PUSH : (k < 75) ? KIND_POP : KIND_TOP;
            endcase
        end
        return item;
    endfunction

    task automatic test_random_traffic();
        for (int p = 0; p < 17; p++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 50; i++)
                send_request(random_request(p % 3));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        clear_pool_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_stacks();
        test_bad_stack_id();
        test_unused_kind();
        test_value_extremes();
        test_random_traffic();

        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
